// File: hdl/rbd_pkg.sv
// Shared constants and types for the RGB bilinear downscaler.
// No dependencies; used by rbd_step_div and rgb_bilinear_downscale_top.
package rbd_pkg;

    // Default geometry and fixed-point resolution
    localparam int MAX_WIDTH_DEF     = 256;
    localparam int MAX_HEIGHT_DEF    = 256;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed widths of the data path
    localparam int COORD_BITS = 8;
    localparam int CH_BITS    = 8;
    localparam int CHANNELS   = 3;
    localparam int PIXEL_BITS = CH_BITS * CHANNELS;
    localparam int SIZE_BITS  = 9;
    localparam int POS_BITS   = 16;
    localparam int STEP_W     = SIZE_BITS + POS_BITS;

    // Stream and register port widths
    localparam int IN_DATA_W  = 2 * COORD_BITS + PIXEL_BITS;
    localparam int OUT_DATA_W = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Size registers come out of reset at 256
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;
    localparam int SIZE_RESET_INT = 256;
    localparam logic [STEP_W-1:0] STEP_RESET =
        STEP_W'(((SIZE_RESET_INT - 1) * 65536) / SIZE_RESET_INT);

    // Output queue depth (covers the pipeline with room to spare)
    localparam int OUT_DEPTH = 8;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } rbd_status_t;

endpackage

// File: hdl/rbd_step_div.sv
// Restoring divider for one axis: step = ((src - 1) << 16) / dst, one bit a cycle.
// Depends on rbd_pkg.
module rbd_step_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rbd_pkg::SIZE_BITS-1:0]  src_size,
    input  logic [rbd_pkg::SIZE_BITS-1:0]  dst_size,
    output logic [rbd_pkg::STEP_W-1:0]     step,
    output logic                           busy
);

    localparam int REM_W = rbd_pkg::SIZE_BITS + 1;
    localparam int CNT_W = $clog2(rbd_pkg::STEP_W + 1);

    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [rbd_pkg::STEP_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [REM_W-1:0]           trial;
    logic                       fits;

    assign trial = {rem_reg[REM_W-2:0], quo_reg[rbd_pkg::STEP_W-1]};
    assign fits  = (trial >= {1'b0, dst_size});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = {src_size - 9'd1, {rbd_pkg::POS_BITS{1'b0}}};
            cnt_next  = CNT_W'(rbd_pkg::STEP_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract when the divisor fits
            rem_next  = fits ? (trial - {1'b0, dst_size}) : trial;
            quo_next  = {quo_reg[rbd_pkg::STEP_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= rbd_pkg::STEP_RESET;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign step = quo_reg;
    assign busy = busy_reg;

endmodule

// File: hdl/rgb_bilinear_downscale_top.sv
// Top level of the RGB bilinear downscaler: banked frame store, blend pipeline,
// output queue and APB size registers. Depends on rbd_pkg and rbd_step_div.
//
//  channel   direction  handshake                 content
//  s_*       in         s_tvalid / s_tready       source pixel write or destination request
//  m_*       out        m_tvalid / m_tready       blended pixel with status
//  apb       in/out     psel, penable, pready     four 9-bit size registers
//
// Throughput: one transfer per cycle on the slave side while s_tready is high; a
//   request's result enters the output queue from stage 4. The rate is set by the four frame
//   store banks (split by row and column parity), each read once per request.
// Reset: no clearing pass; the frame store holds nothing valid until written.
// A size register write recomputes both axis steps in a bit-serial
//   divider; s_tready stays low meanwhile.
// Stalls: an 8-entry output queue with credit counting keeps the pipeline running
//   while m_tready is low; s_tready drops when the credits are used up or a divider is busy.
module rgb_bilinear_downscale_top
#(
    parameter int MAX_WIDTH     = rbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = rbd_pkg::MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = rbd_pkg::FRACTION_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pixel_x[7:0], pixel_y[15:8], blue_in[23:16], green_in[31:24], red_in[39:32]
    input  logic [rbd_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode[0]
    input  logic [0:0]                       s_tuser,
    // master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // blue_out[7:0], green_out[15:8], red_out[23:16], status[25:24], zero above
    output logic [rbd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rbd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rbd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = HALF_W * HALF_H;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int ADDR_CW    = BANK_AW + rbd_pkg::COORD_BITS + 1;
    localparam int SZ         = rbd_pkg::SIZE_BITS;
    localparam int CW         = rbd_pkg::COORD_BITS;
    localparam int PB         = rbd_pkg::PIXEL_BITS;
    localparam int CHB        = rbd_pkg::CH_BITS;
    localparam int POS_W      = rbd_pkg::STEP_W + CW;
    localparam int IPART_W    = POS_W - rbd_pkg::POS_BITS;
    localparam int FB         = FRACTION_BITS;
    localparam int WT1_W      = FB + 1;
    localparam int WT_W       = 2 * WT1_W;
    localparam int PROD_W     = CHB + WT_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int PAY_W      = PB + 2;
    localparam int QPTR_W     = $clog2(rbd_pkg::OUT_DEPTH);
    localparam int QCNT_W     = $clog2(rbd_pkg::OUT_DEPTH + 1);
    localparam logic [WT1_W-1:0] FULL_WT = WT1_W'(1) << FB;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SZ-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic          cfg_wr;
    logic          cfg_wr_q_reg;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg    <= rbd_pkg::SIZE_RESET;
            src_h_reg    <= rbd_pkg::SIZE_RESET;
            dst_w_reg    <= rbd_pkg::SIZE_RESET;
            dst_h_reg    <= rbd_pkg::SIZE_RESET;
            cfg_wr_q_reg <= 1'b0;
        end
        else
        begin
            cfg_wr_q_reg <= cfg_wr;
            if (cfg_wr)
            begin
                unique case (reg_idx)
                    rbd_pkg::REG_SOURCE_WIDTH:  src_w_reg <= pwdata[SZ-1:0];
                    rbd_pkg::REG_SOURCE_HEIGHT: src_h_reg <= pwdata[SZ-1:0];
                    rbd_pkg::REG_TARGET_WIDTH:  dst_w_reg <= pwdata[SZ-1:0];
                    rbd_pkg::REG_TARGET_HEIGHT: dst_h_reg <= pwdata[SZ-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rbd_pkg::REG_SOURCE_WIDTH:  prdata = rbd_pkg::APB_DATA_W'(src_w_reg);
            rbd_pkg::REG_SOURCE_HEIGHT: prdata = rbd_pkg::APB_DATA_W'(src_h_reg);
            rbd_pkg::REG_TARGET_WIDTH:  prdata = rbd_pkg::APB_DATA_W'(dst_w_reg);
            rbd_pkg::REG_TARGET_HEIGHT: prdata = rbd_pkg::APB_DATA_W'(dst_h_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Axis steps: recomputation starts the cycle after any size write, from the new values
    // ------------------------------------------------------------------
    logic [rbd_pkg::STEP_W-1:0] step_x, step_y;
    logic                       div_busy_x, div_busy_y;
    logic                       div_busy;

    rbd_step_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_wr_q_reg),
        .src_size (src_w_reg),
        .dst_size (dst_w_reg),
        .step     (step_x),
        .busy     (div_busy_x)
    );

    rbd_step_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_wr_q_reg),
        .src_size (src_h_reg),
        .dst_size (dst_h_reg),
        .step     (step_y),
        .busy     (div_busy_y)
    );

    assign div_busy = cfg_wr_q_reg | div_busy_x | div_busy_y;

    // ------------------------------------------------------------------
    // Credit check against the output queue
    // ------------------------------------------------------------------
    logic                 s0_valid_reg, s0_mode_reg;
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [QCNT_W-1:0]    q_count_reg, q_count_next;
    logic [QCNT_W-1:0]    inflight;
    logic [QCNT_W:0]      credit_used;
    logic                 s_xfer;

    // requests still in the pipe, each owed one queue slot
    assign inflight = QCNT_W'(s0_valid_reg & s0_mode_reg) + QCNT_W'(s1_valid_reg)
                    + QCNT_W'(s2_valid_reg) + QCNT_W'(s3_valid_reg)
                    + QCNT_W'(s4_valid_reg);
    assign credit_used = (QCNT_W + 1)'(inflight) + (QCNT_W + 1)'(q_count_reg);
    assign s_tready    = !div_busy && (credit_used < (QCNT_W + 1)'(rbd_pkg::OUT_DEPTH));
    assign s_xfer      = s_tvalid & s_tready;

    // ------------------------------------------------------------------
    // Stage 0: accepted transfer; writes go to the frame store from here
    // ------------------------------------------------------------------
    logic [CW-1:0] s0_x_reg, s0_y_reg;
    logic [PB-1:0] s0_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            s0_mode_reg <= s_tuser[0];
            s0_x_reg    <= s_tdata[CW-1:0];
            s0_y_reg    <= s_tdata[2*CW-1:CW];
            s0_pix_reg  <= s_tdata[2*CW +: PB];
        end
    end

    // Status of a request; refusal wins over an outside coordinate
    rbd_pkg::rbd_status_t s1_status_next;
    logic                 cfg_bad, req_outside;

    assign cfg_bad = (src_w_reg == '0) || (src_h_reg == '0) || (dst_w_reg == '0)
                  || (dst_h_reg == '0) || (32'(src_w_reg) > MAX_WIDTH)
                  || (32'(src_h_reg) > MAX_HEIGHT) || (dst_w_reg > src_w_reg)
                  || (dst_h_reg > src_h_reg);
    assign req_outside = ({1'b0, s0_x_reg} >= dst_w_reg) || ({1'b0, s0_y_reg} >= dst_h_reg);

    always_comb
    begin
        if (cfg_bad)
            s1_status_next = rbd_pkg::STATUS_REFUSED;
        else if (req_outside)
            s1_status_next = rbd_pkg::STATUS_OUTSIDE;
        else
            s1_status_next = rbd_pkg::STATUS_OK;
    end

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [CW-1:0] yh,
                                                     input logic [CW-1:0] xh);
        logic [ADDR_CW-1:0] a;
        a = ADDR_CW'(yh) * ADDR_CW'(HALF_W) + ADDR_CW'(xh);
        return a[BANK_AW-1:0];
    endfunction

    logic                wr_ok;
    logic [3:0]          bank_we;
    logic [BANK_AW-1:0]  wr_addr;

    // drop writes that fall outside the store
    assign wr_ok   = s0_valid_reg && !s0_mode_reg && (32'(s0_x_reg) < MAX_WIDTH)
                  && (32'(s0_y_reg) < MAX_HEIGHT);
    assign wr_addr = bank_addr({1'b0, s0_y_reg[CW-1:1]}, {1'b0, s0_x_reg[CW-1:1]});

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            bank_we[b] = wr_ok && ({s0_y_reg[0], s0_x_reg[0]} == 2'(b));
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: source positions (step times coordinate)
    // ------------------------------------------------------------------
    logic [POS_W-1:0]     s1_pos_x_reg, s1_pos_y_reg;
    rbd_pkg::rbd_status_t s1_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg & s0_mode_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pos_x_reg  <= POS_W'(step_x) * POS_W'(s0_x_reg);
        s1_pos_y_reg  <= POS_W'(step_y) * POS_W'(s0_y_reg);
        s1_status_reg <= s1_status_next;
    end

    // Integer part, fraction and neighbor clamp per axis
    logic [SZ-1:0]      w_m1, h_m1;
    logic [IPART_W-1:0] ix, iy;
    logic [IPART_W-1:0] x0_full, y0_full;
    logic [CW-1:0]      x0, y0;
    logic [FB-1:0]      fx, fy;
    logic               x_clamp, y_clamp;
    logic [SZ-1:0]      x_even, x_odd, y_even, y_odd;
    logic [BANK_AW-1:0] rd_addr [4];

    assign w_m1 = src_w_reg - SZ'(1);
    assign h_m1 = src_h_reg - SZ'(1);
    assign ix   = s1_pos_x_reg[POS_W-1:rbd_pkg::POS_BITS];
    assign iy   = s1_pos_y_reg[POS_W-1:rbd_pkg::POS_BITS];
    assign fx   = s1_pos_x_reg[rbd_pkg::POS_BITS-1 -: FB];
    assign fy   = s1_pos_y_reg[rbd_pkg::POS_BITS-1 -: FB];

    always_comb
    begin
        x0_full = (ix > IPART_W'(w_m1)) ? IPART_W'(w_m1) : ix;
        y0_full = (iy > IPART_W'(h_m1)) ? IPART_W'(h_m1) : iy;
        x0      = x0_full[CW-1:0];
        y0      = y0_full[CW-1:0];
        // the far neighbor sits on the last column or row when it would leave the frame
        x_clamp = (({1'b0, x0} + SZ'(1)) >= src_w_reg);
        y_clamp = (({1'b0, y0} + SZ'(1)) >= src_h_reg);
        // the pair (x0, x0+1) always spans one even and one odd column
        x_even  = x0[0] ? ({1'b0, x0} + SZ'(1)) : {1'b0, x0};
        x_odd   = x0[0] ? {1'b0, x0} : ({1'b0, x0} + SZ'(1));
        y_even  = y0[0] ? ({1'b0, y0} + SZ'(1)) : {1'b0, y0};
        y_odd   = y0[0] ? {1'b0, y0} : ({1'b0, y0} + SZ'(1));
        for (int b = 0; b < 4; b++)
        begin
            rd_addr[b] = bank_addr(b[1] ? y_odd[SZ-1:1] : y_even[SZ-1:1],
                                   b[0] ? x_odd[SZ-1:1] : x_even[SZ-1:1]);
        end
    end

    // ------------------------------------------------------------------
    // Frame store: four banks by row/column parity. Writes leave stage 0 and
    // reads leave stage 1, so an earlier write always lands before a later
    // read and a later write never shows in an earlier read.
    // ------------------------------------------------------------------
    logic [PB-1:0] rd_data_reg [4];

    for (genvar gb = 0; gb < 4; gb++)
    begin : g_bank
        logic [PB-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (bank_we[gb])
            begin
                mem[wr_addr] <= s0_pix_reg;
            end
            rd_data_reg[gb] <= mem[rd_addr[gb]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: neighbor data arrives; pick neighbors and form weights
    // ------------------------------------------------------------------
    logic                 s2_x_par_reg, s2_y_par_reg;
    logic                 s2_x_clamp_reg, s2_y_clamp_reg;
    logic [FB-1:0]        s2_fx_reg, s2_fy_reg;
    rbd_pkg::rbd_status_t s2_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_x_par_reg   <= x0[0];
        s2_y_par_reg   <= y0[0];
        s2_x_clamp_reg <= x_clamp;
        s2_y_clamp_reg <= y_clamp;
        s2_fx_reg      <= fx;
        s2_fy_reg      <= fy;
        s2_status_reg  <= s1_status_reg;
    end

    logic [PB-1:0]    pa, pb, pc, pd;
    logic [PB-1:0]    s3_pix_next [4];
    logic [WT1_W-1:0] wx0, wx1, wy0, wy1;
    logic [WT_W-1:0]  s3_wt_next [4];

    always_comb
    begin
        pa = rd_data_reg[{s2_y_par_reg, s2_x_par_reg}];
        pb = rd_data_reg[{s2_y_par_reg, ~s2_x_par_reg}];
        pc = rd_data_reg[{~s2_y_par_reg, s2_x_par_reg}];
        pd = rd_data_reg[{~s2_y_par_reg, ~s2_x_par_reg}];
        // order: (x0,y0), (x1,y0), (x0,y1), (x1,y1)
        s3_pix_next[0] = pa;
        s3_pix_next[1] = s2_x_clamp_reg ? pa : pb;
        s3_pix_next[2] = s2_y_clamp_reg ? pa : pc;
        if (s2_x_clamp_reg)
            s3_pix_next[3] = s2_y_clamp_reg ? pa : pc;
        else
            s3_pix_next[3] = s2_y_clamp_reg ? pb : pd;
        wx1 = {1'b0, s2_fx_reg};
        wy1 = {1'b0, s2_fy_reg};
        wx0 = FULL_WT - wx1;
        wy0 = FULL_WT - wy1;
        s3_wt_next[0] = WT_W'(wx0) * WT_W'(wy0);
        s3_wt_next[1] = WT_W'(wx1) * WT_W'(wy0);
        s3_wt_next[2] = WT_W'(wx0) * WT_W'(wy1);
        s3_wt_next[3] = WT_W'(wx1) * WT_W'(wy1);
    end

    // ------------------------------------------------------------------
    // Stage 3: neighbors and weights registered
    // ------------------------------------------------------------------
    logic [PB-1:0]        s3_pix_reg [4];
    logic [WT_W-1:0]      s3_wt_reg [4];
    rbd_pkg::rbd_status_t s3_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_pix_reg    <= s3_pix_next;
        s3_wt_reg     <= s3_wt_next;
        s3_status_reg <= s2_status_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: per-channel products registered
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]    s4_prod_reg [4][rbd_pkg::CHANNELS];
    rbd_pkg::rbd_status_t s4_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 4; n++)
        begin
            for (int k = 0; k < rbd_pkg::CHANNELS; k++)
            begin
                s4_prod_reg[n][k] <= PROD_W'(s3_pix_reg[n][CHB*k +: CHB])
                                   * PROD_W'(s3_wt_reg[n]);
            end
        end
        s4_status_reg <= s3_status_reg;
    end

    // Sum the four terms, truncate, zero the color on any error
    logic [SUM_W-1:0] ch_sum [rbd_pkg::CHANNELS];
    logic [PB-1:0]    colour;
    logic [PAY_W-1:0] push_data;

    always_comb
    begin
        for (int k = 0; k < rbd_pkg::CHANNELS; k++)
        begin
            ch_sum[k] = SUM_W'(s4_prod_reg[0][k]) + SUM_W'(s4_prod_reg[1][k])
                      + SUM_W'(s4_prod_reg[2][k]) + SUM_W'(s4_prod_reg[3][k]);
            colour[CHB*k +: CHB] = (s4_status_reg == rbd_pkg::STATUS_OK)
                                 ? ch_sum[k][2*FB +: CHB] : '0;
        end
        push_data = {s4_status_reg, colour};
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [PAY_W-1:0]  q_mem_reg [rbd_pkg::OUT_DEPTH];
    logic [QPTR_W-1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic              q_pop;

    assign m_tvalid = (q_count_reg != '0);
    assign q_pop    = m_tvalid & m_tready;
    assign m_tdata  = rbd_pkg::OUT_DATA_W'(q_mem_reg[q_rd_ptr_reg]);

    always_comb
    begin
        q_count_next = q_count_reg;
        if (s4_valid_reg && !q_pop)
            q_count_next = q_count_reg + QCNT_W'(1);
        else if (!s4_valid_reg && q_pop)
            q_count_next = q_count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (s4_valid_reg)
                q_wr_ptr_reg <= q_wr_ptr_reg + QPTR_W'(1);
            if (q_pop)
                q_rd_ptr_reg <= q_rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
            q_mem_reg[q_wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    // credits never oversubscribe the queue
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (QCNT_W + 1)'(rbd_pkg::OUT_DEPTH))
        else $error("output queue credits oversubscribed");

    // a result never arrives at a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (q_count_reg != QCNT_W'(rbd_pkg::OUT_DEPTH)))
        else $error("push into full output queue");

    // every accepted request reaches the queue
    a_req_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |-> ##5 s4_valid_reg)
        else $error("request lost in pipeline");

    // writes never produce a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0]) |=> ##1 !s1_valid_reg)
        else $error("write produced a result");
`endif

endmodule

// File: sim/rgb_bilinear_downscale_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for rgb_bilinear_downscale_top: frame writes, scaled pixel
// requests and size register programming, predicted in-bench. Depends on rbd_pkg.
module rgb_bilinear_downscale_top_tb;

    import rbd_pkg::*;

    localparam int          CLK_HALF        = 10;
    localparam int          SETTLE_CYCLES   = 12;         // pipeline is 5 deep; leave margin
    localparam int          LONG_HOLD       = 300;        // receiver hold-off for back-pressure
    localparam int          RAND_PHASES     = 16;
    localparam int          ITEMS_PER_PHASE = 50;
    localparam int          PRESSURE_PHASE  = 2;
    localparam int          MAX_PRINTS      = 50;
    localparam longint      RUN_LIMIT_NS    = 64'd40_000_000;
    localparam int unsigned FULL_WEIGHT     = 1 << FRACTION_BITS_DEF;

    typedef enum logic {
        MODE_WRITE   = 1'b0,
        MODE_REQUEST = 1'b1
    } px_mode_t;

    // One slave-side transfer: mode goes on tuser, the rest is tdata
    typedef struct packed {
        px_mode_t   mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pixel_y;
        logic [7:0] pixel_x;
    } px_cmd_t;

    // One master-side transfer, laid out exactly as m_tdata
    typedef struct packed {
        logic [5:0] pad;
        logic [1:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } px_result_t;

    // Row of the directed plan: either a size setting or one transfer
    typedef struct {
        bit         is_cfg;
        logic [8:0] sw, sh, tw, th;
        px_cmd_t    cmd;
        bit         typed;
        px_result_t want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;    // pixel_x, pixel_y, blue_in, green_in, red_in
    logic [0:0]              s_tuser;    // mode
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;    // blue_out, green_out, red_out, status, zero pad
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Predictor state: size registers and a shadow of the frame store
    logic [8:0]  cfg_src_w = SIZE_RESET;
    logic [8:0]  cfg_src_h = SIZE_RESET;
    logic [8:0]  cfg_tgt_w = SIZE_RESET;
    logic [8:0]  cfg_tgt_h = SIZE_RESET;
    logic [23:0] frame_img   [0:65535];
    bit          frame_valid [0:65535];

    px_result_t  pending_pixels[$];
    plan_row_t   plan_q[$];

    int unsigned mismatch_count = 0;
    int unsigned n_writes       = 0;
    int unsigned n_requests     = 0;
    int unsigned n_settings     = 0;
    int unsigned n_status[3]    = '{0, 0, 0};
    bit          sender_fast    = 0;
    bit          sink_fast      = 0;
    bit          long_hold_req  = 0;

    rgb_bilinear_downscale_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case a result or a handshake never comes
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d results still pending", pending_pixels.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Refused sizes take priority over an out-of-range coordinate
    function automatic rbd_status_t size_status(input logic [7:0] x, input logic [7:0] y);
        if (cfg_src_w == 0 || cfg_src_h == 0 || cfg_tgt_w == 0 || cfg_tgt_h == 0 ||
            cfg_src_w > MAX_WIDTH_DEF || cfg_src_h > MAX_HEIGHT_DEF ||
            cfg_tgt_w > cfg_src_w || cfg_tgt_h > cfg_src_h)
            return STATUS_REFUSED;
        if ({1'b0, x} >= cfg_tgt_w || {1'b0, y} >= cfg_tgt_h)
            return STATUS_OUTSIDE;
        return STATUS_OK;
    endfunction

    // Map one destination coordinate onto the source axis: 9.16 step times coordinate
    function automatic void axis_locate(input logic [8:0] src, input logic [8:0] dst,
                                        input logic [7:0] coord,
                                        output logic [7:0] near, output logic [7:0] far,
                                        output logic [7:0] frac);
        longint unsigned step;
        longint unsigned pos;
        longint unsigned ipart;
        longint unsigned last;
        last  = 64'(src) - 64'd1;
        step  = (last << POS_BITS) / 64'(dst);
        pos   = step * 64'(coord);
        ipart = pos >> POS_BITS;
        frac  = 8'(pos >> (POS_BITS - FRACTION_BITS_DEF));
        // Clamp to the last column or row; the far tap then carries zero weight
        if (ipart > last)
            ipart = last;
        near = 8'(ipart);
        far  = (ipart + 1 < 64'(src)) ? 8'(ipart + 1) : 8'(last);
    endfunction

    // Frame store indexes of the four taps: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    function automatic void corner_taps(input logic [7:0] x, input logic [7:0] y,
                                        output logic [3:0][15:0] tap,
                                        output logic [7:0] fx, output logic [7:0] fy);
        logic [7:0] x0, x1, y0, y1;
        axis_locate(cfg_src_w, cfg_tgt_w, x, x0, x1, fx);
        axis_locate(cfg_src_h, cfg_tgt_h, y, y0, y1, fy);
        tap[0] = {y0, x0};
        tap[1] = {y0, x1};
        tap[2] = {y1, x0};
        tap[3] = {y1, x1};
    endfunction

    function automatic px_result_t blend_pixel(input logic [7:0] x, input logic [7:0] y);
        px_result_t       res;
        rbd_status_t      st;
        logic [3:0][15:0] tap;
        logic [3:0][23:0] pix;
        logic [2:0][7:0]  ch;
        logic [7:0]       fx, fy;
        longint unsigned  wx0, wx1, wy0, wy1, acc;
        res = '0;
        st  = size_status(x, y);
        res.status = st;
        if (st == STATUS_OK)
        begin
            corner_taps(x, y, tap, fx, fy);
            for (int k = 0; k < 4; k++)
                pix[k] = frame_img[tap[k]];
            wx1 = 64'(fx);
            wy1 = 64'(fy);
            wx0 = 64'(FULL_WEIGHT) - wx1;
            wy0 = 64'(FULL_WEIGHT) - wy1;
            for (int k = 0; k < CHANNELS; k++)
            begin
                acc = 64'(pix[0][8*k +: 8]) * wx0 * wy0 +
                      64'(pix[1][8*k +: 8]) * wx1 * wy0 +
                      64'(pix[2][8*k +: 8]) * wx0 * wy1 +
                      64'(pix[3][8*k +: 8]) * wx1 * wy1;
                ch[k] = 8'(acc >> (2 * FRACTION_BITS_DEF));
            end
            res.blue  = ch[0];
            res.green = ch[1];
            res.red   = ch[2];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch, %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input px_result_t got);
        px_result_t want;
        if (got.status < 3)
            n_status[got.status]++;
        if (pending_pixels.size() == 0)
        begin
            flag_mismatch("result with nothing pending", got, 0);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.blue !== want.blue)
            flag_mismatch("blue_out", got.blue, want.blue);
        if (got.green !== want.green)
            flag_mismatch("green_out", got.green, want.green);
        if (got.red !== want.red)
            flag_mismatch("red_out", got.red, want.red);
        if (got.status !== want.status)
            flag_mismatch("status", got.status, want.status);
        if (got.pad !== want.pad)
            flag_mismatch("tdata pad bits", got.pad, want.pad);
    endtask

    // Receiver: per transfer draw a random wait (none when sink_fast is set); a hold-off request
    // keeps tready low for a long stretch, counted here
    initial
    begin : result_sink
        int unsigned wait_left;
        bit          took;
        px_result_t  word;
        wait_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            took = m_tvalid && m_tready;
            word = m_tdata;
            @(posedge clk);
            if (took)
            begin
                check_result(word);
                wait_left = sink_fast ? 0 : $urandom_range(0, 8);
            end
            if (long_hold_req)
            begin
                long_hold_req = 0;
                wait_left = LONG_HOLD;
            end
            if (wait_left > 0)
            begin
                m_tready <= 1'b0;
                wait_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one transfer after a random gap and hold it until accepted; update
    // the shadow store or queue the expected pixel at the accepting edge
    task automatic send_item(input px_cmd_t c, input bit typed, input px_result_t want);
        int unsigned gap;
        bit          rdy;
        gap = sender_fast ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c[IN_DATA_W-1:0];
        s_tuser  <= c.mode;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        if (c.mode == MODE_WRITE)
        begin
            frame_img[{c.pixel_y, c.pixel_x}]   = {c.red, c.green, c.blue};
            frame_valid[{c.pixel_y, c.pixel_x}] = 1'b1;
            n_writes++;
        end
        else
        begin
            pending_pixels.push_back(typed ? want : blend_pixel(c.pixel_x, c.pixel_y));
            n_requests++;
        end
    endtask

    function automatic px_cmd_t random_cmd(input px_mode_t mode);
        px_cmd_t c;
        c.mode    = mode;
        c.red     = 8'($urandom);
        c.green   = 8'($urandom);
        c.blue    = 8'($urandom);
        c.pixel_y = 8'($urandom);
        c.pixel_x = 8'($urandom);
        return c;
    endfunction

    // Request a destination pixel; fill any tap that was never written first,
    // so that no read of an undefined store entry is ever caused
    task automatic request_pixel(input logic [7:0] x, input logic [7:0] y);
        px_cmd_t          c;
        logic [3:0][15:0] tap;
        logic [7:0]       fx, fy;
        if (size_status(x, y) == STATUS_OK)
        begin
            corner_taps(x, y, tap, fx, fy);
            for (int k = 0; k < 4; k++)
                if (!frame_valid[tap[k]])
                begin
                    c = random_cmd(MODE_WRITE);
                    c.pixel_x = tap[k][7:0];
                    c.pixel_y = tap[k][15:8];
                    send_item(c, 1'b0, '0);
                end
        end
        c = random_cmd(MODE_REQUEST);
        c.pixel_x = x;
        c.pixel_y = y;
        send_item(c, 1'b0, '0);
    endtask

    // Wait until every expected pixel is in, then let the pipeline empty
    // (writes give no result but may still be in flight)
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one size register, read it back, then leave the bus idle
    task automatic apb_size(input logic [1:0] idx, input logic [8:0] val);
        bit          rdy;
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        while (!rdy);
        // Register takes the value at this edge; go straight into a read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            rd  = prdata;
            @(posedge clk);
        end
        while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_SOURCE_WIDTH:  cfg_src_w = val;
            REG_SOURCE_HEIGHT: cfg_src_h = val;
            REG_TARGET_WIDTH:  cfg_tgt_w = val;
            default:           cfg_tgt_h = val;
        endcase
        if (rd !== {23'd0, val})
            flag_mismatch("size register read-back", rd, {23'd0, val});
    endtask

    task automatic set_sizes(input logic [8:0] sw, input logic [8:0] sh,
                             input logic [8:0] tw, input logic [8:0] th);
        drain_results();
        apb_size(REG_SOURCE_WIDTH, sw);
        apb_size(REG_SOURCE_HEIGHT, sh);
        apb_size(REG_TARGET_WIDTH, tw);
        apb_size(REG_TARGET_HEIGHT, th);
        n_settings++;
    endtask

    // Directed plan builders
    task automatic plan_cfg(input logic [8:0] sw, input logic [8:0] sh,
                            input logic [8:0] tw, input logic [8:0] th);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.sw = sw;
        r.sh = sh;
        r.tw = tw;
        r.th = th;
        plan_q.push_back(r);
    endtask

    task automatic plan_write(input logic [7:0] x, input logic [7:0] y, input logic [7:0] b,
                              input logic [7:0] g, input logic [7:0] rd);
        plan_row_t r;
        r = '{default: '0};
        r.cmd = '{MODE_WRITE, rd, g, b, y, x};
        plan_q.push_back(r);
    endtask

    // typed=1 gives the expected pixel inline; otherwise the predictor decides
    task automatic plan_req(input logic [7:0] x, input logic [7:0] y, input bit typed,
                            input rbd_status_t st, input logic [7:0] b,
                            input logic [7:0] g, input logic [7:0] rd);
        plan_row_t r;
        r = '{default: '0};
        r.cmd   = '{MODE_REQUEST, 8'hFF, 8'hFF, 8'hFF, y, x};
        r.typed = typed;
        r.want  = '{6'd0, st, rd, g, b};
        plan_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int unsigned roll;
        logic [8:0]  sw, sh, tw, th;
        px_cmd_t     c;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Sizes start at their reset value of 256 on every axis.
        plan_write(8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF);
        plan_write(8'd1, 8'd0, 8'h00, 8'hFF, 8'h00);
        plan_write(8'd0, 8'd1, 8'h55, 8'hAA, 8'h0F);
        plan_write(8'd1, 8'd1, 8'hAA, 8'h55, 8'hF0);
        // Zero fraction at the origin: the top-left tap alone
        plan_req(8'd0, 8'd0, 1'b1, STATUS_OK, 8'hFF, 8'h00, 8'hFF);
        plan_write(8'd254, 8'd254, 8'hFF, 8'hFF, 8'hFF);
        plan_write(8'd255, 8'd254, 8'h00, 8'h00, 8'h00);
        plan_write(8'd254, 8'd255, 8'h12, 8'h34, 8'h56);
        plan_write(8'd255, 8'd255, 8'hFF, 8'h00, 8'hFF);
        plan_req(8'd255, 8'd255, 1'b0, STATUS_OK, 8'h00, 8'h00, 8'h00);
        // Upscaling, zero sizes and an oversized source are all refused
        plan_cfg(9'd256, 9'd256, 9'd257, 9'd256);
        plan_req(8'd0, 8'd0, 1'b1, STATUS_REFUSED, 8'h00, 8'h00, 8'h00);
        plan_cfg(9'd0, 9'd256, 9'd1, 9'd1);
        plan_req(8'd0, 8'd0, 1'b1, STATUS_REFUSED, 8'h00, 8'h00, 8'h00);
        plan_cfg(9'd511, 9'd256, 9'd1, 9'd1);
        plan_req(8'd0, 8'd0, 1'b1, STATUS_REFUSED, 8'h00, 8'h00, 8'h00);
        plan_cfg(9'd256, 9'd256, 9'd256, 9'd0);
        plan_req(8'd0, 8'd0, 1'b1, STATUS_REFUSED, 8'h00, 8'h00, 8'h00);
        // Refusal wins over a coordinate outside the destination
        plan_cfg(9'd10, 9'd10, 9'd20, 9'd5);
        plan_req(8'd50, 8'd0, 1'b1, STATUS_REFUSED, 8'h00, 8'h00, 8'h00);
        plan_cfg(9'd256, 9'd256, 9'd100, 9'd100);
        plan_req(8'd100, 8'd5, 1'b1, STATUS_OUTSIDE, 8'h00, 8'h00, 8'h00);
        plan_req(8'd5, 8'd255, 1'b1, STATUS_OUTSIDE, 8'h00, 8'h00, 8'h00);
        plan_req(8'd0, 8'd0, 1'b1, STATUS_OK, 8'hFF, 8'h00, 8'hFF);
        plan_req(8'd255, 8'd0, 1'b1, STATUS_OUTSIDE, 8'h00, 8'h00, 8'h00);
        // One-pixel source: right and lower taps clamp onto the pixel itself
        plan_cfg(9'd1, 9'd1, 9'd1, 9'd1);
        plan_req(8'd0, 8'd0, 1'b1, STATUS_OK, 8'hFF, 8'h00, 8'hFF);
        plan_req(8'd1, 8'd0, 1'b1, STATUS_OUTSIDE, 8'h00, 8'h00, 8'h00);
        // One column, halfway down a tall source
        plan_cfg(9'd1, 9'd256, 9'd1, 9'd2);
        plan_write(8'd0, 8'd127, 8'h80, 8'h01, 8'hFE);
        plan_write(8'd0, 8'd128, 8'h7F, 8'hFF, 8'h03);
        plan_req(8'd0, 8'd1, 1'b0, STATUS_OK, 8'h00, 8'h00, 8'h00);

        foreach (plan_q[i])
        begin
            if (plan_q[i].is_cfg)
                set_sizes(plan_q[i].sw, plan_q[i].sh, plan_q[i].tw, plan_q[i].th);
            else
                send_item(plan_q[i].cmd, plan_q[i].typed, plan_q[i].want);
        end

        // Random part: one size setting per phase, then a mix of transfers
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    sw = 9'd256; sh = 9'd256; tw = 9'd1; th = 9'd1;
                end
                1:
                begin
                    sw = 9'd256; sh = 9'd256; tw = 9'd256; th = 9'd256;
                end
                2:
                begin
                    sw = 9'd1; sh = 9'($urandom_range(1, 256));
                    tw = 9'd1; th = 9'($urandom_range(1, sh));
                end
                3:
                begin
                    sh = 9'd1; sw = 9'($urandom_range(1, 256));
                    th = 9'd1; tw = 9'($urandom_range(1, sw));
                end
                4:
                begin
                    sw = 9'($urandom_range(1, 200));
                    sh = 9'($urandom_range(1, 200));
                    tw = 9'($urandom_range(1, sw));
                    th = 9'($urandom_range(1, sh));
                    case ($urandom_range(0, 3))
                        0:       tw = 9'(sw + $urandom_range(1, 511 - sw));
                        1:       th = 9'(sh + $urandom_range(1, 511 - sh));
                        2:       sw = 9'($urandom_range(257, 511));
                        default:
                        begin
                            roll = $urandom_range(0, 3);
                            if (roll == 0) sw = '0;
                            else if (roll == 1) sh = '0;
                            else if (roll == 2) tw = '0;
                            else th = '0;
                        end
                    endcase
                end
                default:
                begin
                    sw = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(2, 256))
                                                     : 9'($urandom_range(1, 20));
                    sh = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(2, 256))
                                                     : 9'($urandom_range(1, 20));
                    tw = 9'($urandom_range(1, sw));
                    th = 9'($urandom_range(1, sh));
                end
            endcase
            if (phase == PRESSURE_PHASE)
            begin
                sw = 9'd8; sh = 9'd8; tw = 9'd4; th = 9'd4;
            end
            set_sizes(sw, sh, tw, th);

            // Every fifth phase runs with no idling on either side
            sender_fast = (phase % 5 == 4);
            sink_fast   = (phase % 5 == 4);
            if (phase == PRESSURE_PHASE)
            begin
                // Hold the receiver off and keep offering back-to-back requests
                // until the output queue fills and tready drops
                sender_fast   = 1;
                long_hold_req = 1;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                if (phase == PRESSURE_PHASE || (roll < 70 &&
                    size_status(8'd0, 8'd0) != STATUS_REFUSED))
                    request_pixel(8'($urandom_range(0, cfg_tgt_w - 1)),
                                  8'($urandom_range(0, cfg_tgt_h - 1)));
                else if (roll < 85)
                begin
                    c = random_cmd(MODE_WRITE);
                    send_item(c, 1'b0, '0);
                end
                else
                    request_pixel(8'($urandom), 8'($urandom));
            end
        end

        drain_results();
        sender_fast = 0;
        sink_fast   = 0;

        $display("covered %0d frame writes and %0d pixel requests over %0d size settings",
                 n_writes, n_requests, n_settings);
        $display("results seen: %0d ok, %0d refused, %0d outside destination",
                 n_status[STATUS_OK], n_status[STATUS_REFUSED], n_status[STATUS_OUTSIDE]);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
